/* design/coulomb_damper_friction_force_macros.svh */
// Assertion macros for the friction damper top level.
`ifndef COULOMB_DAMPER_FRICTION_FORCE_MACROS_SVH
`define COULOMB_DAMPER_FRICTION_FORCE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define CDFF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cdff assertion failed");
// Check a property on every clock edge, reset included.
`define CDFF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cdff assertion failed");
`else
`define CDFF_ASSERT(lbl, clk, rstn, prop)
`define CDFF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* design/cdff_pkg.sv */
// Package with types, codes and constants of the friction damper.
`default_nettype none
package cdff_pkg;

    localparam int CDFF_QDEPTH    = 2;
    localparam int FRAC_BITS      = 16;
    localparam int DIV_BITS       = 47;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [1:0] {
        KIND_TRIAL         = 2'd0,
        KIND_COMMIT        = 2'd1,
        KIND_REVERT_COMMIT = 2'd2,
        KIND_REVERT_START  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_STIFFNESS      = 3'd0,
        REG_FRICTION_FORCE = 3'd1,
        REG_RATE_TOLERANCE = 3'd2,
        REG_DAMP_OUT_SLOPE = 3'd3,
        REG_DAMP_MODE      = 3'd4,
        REG_FLIP_LIMIT     = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_LINEAR  = 2'd1,
        MODE_SCALED  = 2'd2,
        MODE_VISCOUS = 2'd3
    } t_damp_mode;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL_A,
        BK_MUL_B,
        BK_TERM,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] strain;
        logic signed [31:0] strain_rate;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] stress;
        logic signed [31:0] damp_tangent;
        logic [7:0]         flip_count;
    } t_out_res;

    typedef struct packed {
        logic signed [31:0] strain;
        logic signed [31:0] rate;
        logic [7:0]         count;
    } t_job;

    typedef struct packed {
        logic signed [31:0] stiffness;
        logic [30:0]        friction_force;
        logic [30:0]        tol;
        logic signed [31:0] damp_out_slope;
        logic [1:0]         damp_mode;
        logic [7:0]         flip_limit;
    } t_cfg;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

/* design/coulomb_damper_friction_force.sv */
// Top level of the Coulomb friction damper: configuration registers and block wiring.
//
// Q16.16 friction damper. The front end takes one request per cycle while its
// job queue has room and updates the trial/commit state at once; the back end
// handles one job at a time: it takes the job, runs the bit-serial
// friction/tolerance divider, multiplies stiffness by strain and then slope by
// rate on the shared 32x32 multiplier, forms the friction term and loads the
// output register once it is free, and only then takes a new job.
// Write registers only while no request is in flight; the block does not enforce it.
`default_nettype none
`include "coulomb_damper_friction_force_macros.svh"
module coulomb_damper_friction_force
    import cdff_pkg::*;
#(
    parameter int QDEPTH = CDFF_QDEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in_req               i_req,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out_res                   o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [31:0] r_stiffness;
    logic [30:0]        r_friction;
    logic [30:0]        r_tol;
    logic signed [31:0] r_damp_slope;
    logic [1:0]         r_damp_mode;
    logic [7:0]         r_flip_limit;

    t_cfg      w_cfg;
    t_job      w_push_job, w_pop_job;
    t_q_status w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness  <= 32'sd0;
            r_friction   <= 31'd0;
            r_tol        <= 31'd1;
            r_damp_slope <= 32'sd65536;
            r_damp_mode  <= MODE_LINEAR;
            r_flip_limit <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STIFFNESS:      r_stiffness  <= $signed(i_cfg_data);
                REG_FRICTION_FORCE: r_friction   <= i_cfg_data[30:0];
                REG_RATE_TOLERANCE: r_tol        <= i_cfg_data[30:0];
                REG_DAMP_OUT_SLOPE: r_damp_slope <= $signed(i_cfg_data);
                REG_DAMP_MODE:      r_damp_mode  <= i_cfg_data[1:0];
                REG_FLIP_LIMIT:     r_flip_limit <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // A zero tolerance acts as one LSB.
    assign w_cfg.stiffness      = r_stiffness;
    assign w_cfg.friction_force = r_friction;
    assign w_cfg.tol            = (r_tol == 31'd0) ? 31'd1 : r_tol;
    assign w_cfg.damp_out_slope = r_damp_slope;
    assign w_cfg.damp_mode      = r_damp_mode;
    assign w_cfg.flip_limit     = r_flip_limit;

    cdff_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_req    (i_req),
        .i_cfg    (w_cfg),
        .i_q_full (w_q.full),
        .o_push   (w_q.push),
        .o_job    (w_push_job)
    );

    cdff_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q.push),
        .i_job   (w_push_job),
        .i_pop   (w_q.pop),
        .o_job   (w_pop_job),
        .o_full  (w_q.full),
        .o_empty (w_q.empty)
    );

    cdff_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_empty (w_q.empty),
        .i_job     (w_pop_job),
        .o_pop     (w_q.pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (o_res)
    );

    `CDFF_ASSERT(a_no_push_full, i_clk, i_rst_n, w_q.push |-> !w_q.full)
    `CDFF_ASSERT(a_no_pop_empty, i_clk, i_rst_n, w_q.pop |-> !w_q.empty)
    `CDFF_ASSERT(a_stall_when_full, i_clk, i_rst_n, w_q.full |-> o_stall)
    `CDFF_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !$past(i_rst_n) |-> !o_valid)

endmodule
`default_nettype wire

/* design/cdff_front.sv */
// Front end: accepts requests, updates trial and commit state, queues jobs.
`default_nettype none
module cdff_front
    import cdff_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_in_req i_req,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_q_full,
    output logic         o_push,
    output t_job         o_job
);

    logic signed [31:0] r_strain, n_strain;
    logic signed [31:0] r_rate, n_rate;
    logic signed [31:0] r_committed, n_committed;
    logic [7:0]         r_count, n_count;
    logic signed [32:0] w_tol, w_rate33, w_com33;
    logic               w_flip, w_accept;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_tol    = $signed({2'b00, i_cfg.tol});
    assign w_rate33 = $signed({i_req.strain_rate[31], i_req.strain_rate});
    assign w_com33  = $signed({r_committed[31], r_committed});
    assign w_flip   = (w_com33 > 33'sd0 && w_rate33 < -w_tol) ||
                      (w_com33 < 33'sd0 && w_rate33 > w_tol);

    always_comb begin
        n_strain    = r_strain;
        n_rate      = r_rate;
        n_committed = r_committed;
        n_count     = r_count;
        unique case (t_kind'(i_req.kind))
            KIND_TRIAL: begin
                n_strain = i_req.strain;
                n_rate   = i_req.strain_rate;
                if (w_flip && r_count != 8'hFF) begin
                    n_count = r_count + 8'd1;
                end
            end
            KIND_COMMIT: begin
                n_committed = r_rate;
                n_count     = 8'd0;
            end
            KIND_REVERT_COMMIT: begin
                n_rate  = r_committed;
                n_count = 8'd0;
            end
            KIND_REVERT_START: begin
                n_strain    = 32'sd0;
                n_rate      = 32'sd0;
                n_committed = 32'sd0;
                n_count     = 8'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strain    <= 32'sd0;
            r_rate      <= 32'sd0;
            r_committed <= 32'sd0;
            r_count     <= 8'd0;
        end else if (w_accept) begin
            r_strain    <= n_strain;
            r_rate      <= n_rate;
            r_committed <= n_committed;
            r_count     <= n_count;
        end
    end

    assign o_push       = w_accept;
    assign o_job.strain = n_strain;
    assign o_job.rate   = n_rate;
    assign o_job.count  = n_count;

endmodule
`default_nettype wire

/* design/cdff_queue.sv */
// Short job queue between the front end and the back end.
`default_nettype none
module cdff_queue
    import cdff_pkg::*;
#(
    parameter int DEPTH = CDFF_QDEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            priority if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* design/cdff_back.sv */
// Back end: divides friction by tolerance, forms stress and tangent, holds the result.
`default_nettype none
module cdff_back
    import cdff_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_empty,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out_res  o_res
);

    t_back_state r_state, n_state;

    t_job                  r_job;
    logic [DIV_BITS-1:0]   r_quo;
    logic [30:0]           r_rem;
    logic [5:0]            r_cnt;
    logic signed [63:0]    r_prod_a, r_prod_b, r_term;
    logic signed [31:0]    r_tan;
    t_out_res              r_out;
    logic                  r_out_valid;

    logic                  w_load, w_div, w_mul_a, w_mul_b, w_term, w_done_take;
    logic [31:0]           w_rem_sh;
    logic                  w_ge;
    logic [30:0]           w_slope;
    logic                  w_damp;
    logic [8:0]            w_k9;
    logic [5:0]            w_kc;
    logic [8:0]            w_sh9;
    logic [5:0]            w_sh;
    logic signed [32:0]    w_rate33, w_tol33;
    logic                  w_gt, w_lt;
    logic signed [31:0]    w_mul_x, w_mul_y;
    logic signed [63:0]    w_prod;
    logic signed [63:0]    n_term;
    logic signed [31:0]    n_tan;
    logic [30:0]           w_fsh;
    logic signed [63:0]    w_sum;
    logic signed [31:0]    w_stress;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (!i_q_empty) n_state = BK_DIV;
            BK_DIV:   if (r_cnt == 6'd0) n_state = BK_MUL_A;
            BK_MUL_A: n_state = BK_MUL_B;
            BK_MUL_B: n_state = BK_TERM;
            BK_TERM:  n_state = BK_DONE;
            BK_DONE:  if (!r_out_valid || !i_stall) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        w_load      = 1'b0;
        w_div       = 1'b0;
        w_mul_a     = 1'b0;
        w_mul_b     = 1'b0;
        w_term      = 1'b0;
        w_done_take = 1'b0;
        unique case (r_state)
            BK_IDLE:  w_load      = !i_q_empty;
            BK_DIV:   w_div       = 1'b1;
            BK_MUL_A: w_mul_a     = 1'b1;
            BK_MUL_B: w_mul_b     = 1'b1;
            BK_TERM:  w_term      = 1'b1;
            BK_DONE:  w_done_take = !r_out_valid || !i_stall;
            default: begin
            end
        endcase
    end

    assign o_pop = w_load;

    // One restoring division step per cycle.
    assign w_rem_sh = {r_rem, r_quo[DIV_BITS-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, i_cfg.tol});
    assign w_slope  = (|r_quo[DIV_BITS-1:31]) ? 31'h7FFF_FFFF : r_quo[30:0];

    assign w_damp = (r_job.count > i_cfg.flip_limit);
    assign w_k9   = ({1'b0, r_job.count} + 9'd1) >> 1;
    assign w_kc   = (w_k9 > 9'd63) ? 6'd63 : w_k9[5:0];
    assign w_sh9  = w_k9 + 9'(FRAC_BITS);
    assign w_sh   = (w_sh9 > 9'd63) ? 6'd63 : w_sh9[5:0];

    assign w_rate33 = $signed({r_job.rate[31], r_job.rate});
    assign w_tol33  = $signed({2'b00, i_cfg.tol});
    assign w_gt     = (w_rate33 > w_tol33);
    assign w_lt     = (w_rate33 < -w_tol33);

    // Shared multiplier: stiffness*strain, then slope*rate (damp-out slope*rate in viscous damp-out).
    always_comb begin
        if (w_mul_a) begin
            w_mul_x = i_cfg.stiffness;
            w_mul_y = r_job.strain;
        end else begin
            w_mul_x = (w_damp && i_cfg.damp_mode == MODE_VISCOUS) ?
                      i_cfg.damp_out_slope : $signed({1'b0, w_slope});
            w_mul_y = r_job.rate;
        end
    end
    assign w_prod = w_mul_x * w_mul_y;

    assign w_fsh = i_cfg.friction_force >> w_kc;

    always_comb begin
        n_term = 64'sd0;
        n_tan  = 32'sd0;
        if (w_damp) begin
            unique case (t_damp_mode'(i_cfg.damp_mode))
                MODE_LINEAR: begin
                    n_term = r_prod_b >>> w_sh;
                    n_tan  = $signed({1'b0, w_slope >> w_kc});
                end
                MODE_SCALED: begin
                    if (w_gt) begin
                        n_term = $signed({33'd0, w_fsh});
                    end else if (w_lt) begin
                        n_term = -$signed({33'd0, w_fsh});
                    end
                end
                MODE_VISCOUS: begin
                    n_term = r_prod_b >>> FRAC_BITS;
                    n_tan  = i_cfg.damp_out_slope;
                end
                default: begin
                end
            endcase
        end else if (!w_gt && !w_lt && w_rate33 != w_tol33 && w_rate33 != -w_tol33) begin
            n_term = r_prod_b >>> FRAC_BITS;
            n_tan  = $signed({1'b0, w_slope});
        end else if (w_gt) begin
            n_term = $signed({33'd0, i_cfg.friction_force});
        end else if (w_lt) begin
            n_term = -$signed({33'd0, i_cfg.friction_force});
        end
    end

    assign w_sum = (r_prod_a >>> FRAC_BITS) + r_term;
    always_comb begin
        priority if (w_sum > 64'sd2147483647) begin
            w_stress = 32'sh7FFF_FFFF;
        end else if (w_sum < -64'sd2147483648) begin
            w_stress = 32'sh8000_0000;
        end else begin
            w_stress = w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_job;
            r_quo <= {i_cfg.friction_force, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_cnt <= 6'(DIV_BITS - 1);
        end
        if (w_div) begin
            r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
            r_rem <= w_ge ? 31'(w_rem_sh - {1'b0, i_cfg.tol}) : w_rem_sh[30:0];
            r_cnt <= r_cnt - 6'd1;
        end
        if (w_mul_a) begin
            r_prod_a <= w_prod;
        end
        if (w_mul_b) begin
            r_prod_b <= w_prod;
        end
        if (w_term) begin
            r_term <= n_term;
            r_tan  <= n_tan;
        end
        if (w_done_take) begin
            r_out.stress       <= w_stress;
            r_out.damp_tangent <= r_tan;
            r_out.flip_count   <= r_job.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule
`default_nettype wire

/* verif/coulomb_damper_friction_force_checker.sv */
// Checker for the friction damper: predicts each result from accepted requests and compares.
`timescale 1ns / 1ps
module coulomb_damper_friction_force_checker
    import cdff_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_stall_in,
    input  wire t_in_req               i_req,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_stall,
    input  wire t_out_res              i_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results
);

    // model copy of registers and state
    logic signed [63:0] m_stiff, m_dslope, m_strain, m_rate, m_crate;
    logic [30:0]        m_fric, m_tol;
    logic [1:0]         m_mode;
    logic [7:0]         m_limit, m_count;
    t_out_res           expected_q[$];

    function automatic logic signed [63:0] fshift(logic signed [63:0] x, int k);
        if (k > 63) k = 63;
        return x >>> k;
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic t_out_res damper_result();
        logic signed [63:0] tol, slope, term, tng, f, st;
        logic signed [63:0] st_c, tn_c;
        int k;
        t_out_res r;
        tol   = (m_tol == 0) ? 64'sd1 : $signed({33'd0, m_tol});
        slope = $signed(({33'd0, m_fric} << FRAC_BITS) / tol);
        if (slope > 64'sd2147483647) slope = 64'sd2147483647;
        k    = (m_count + 1) / 2;
        term = 0;
        tng  = 0;
        if (m_count > m_limit) begin
            case (t_damp_mode'(m_mode))
                MODE_LINEAR: begin
                    term = fshift(slope * m_rate, FRAC_BITS + k);
                    tng  = fshift(slope, k);
                end
                MODE_SCALED: begin
                    f = fshift($signed({33'd0, m_fric}), k);
                    if (m_rate > tol) term = f;
                    else if (m_rate < -tol) term = -f;
                end
                MODE_VISCOUS: begin
                    term = fshift(m_dslope * m_rate, FRAC_BITS);
                    tng  = m_dslope;
                end
                default: ;
            endcase
        end else if (m_rate > -tol && m_rate < tol) begin
            term = fshift(slope * m_rate, FRAC_BITS);
            tng  = slope;
        end else if (m_rate > tol) begin
            term = $signed({33'd0, m_fric});
        end else if (m_rate < -tol) begin
            term = -$signed({33'd0, m_fric});
        end
        st = fshift(m_stiff * m_strain, FRAC_BITS) + term;
        st_c = clamp32(st);
        tn_c = clamp32(tng);
        r.stress       = st_c[31:0];
        r.damp_tangent = tn_c[31:0];
        r.flip_count   = m_count;
        return r;
    endfunction

    task automatic apply_request(t_in_req q);
        logic signed [63:0] tol;
        tol = (m_tol == 0) ? 64'sd1 : $signed({33'd0, m_tol});
        case (t_kind'(q.kind))
            KIND_TRIAL: begin
                m_strain = 64'(q.strain);
                m_rate   = 64'(q.strain_rate);
                if ((m_crate > 0 && m_rate < -tol) || (m_crate < 0 && m_rate > tol))
                    if (m_count != 8'd255) m_count++;
            end
            KIND_COMMIT: begin
                m_crate = m_rate;
                m_count = '0;
            end
            KIND_REVERT_COMMIT: begin
                m_rate  = m_crate;
                m_count = '0;
            end
            default: begin
                m_strain = '0;
                m_rate   = '0;
                m_crate  = '0;
                m_count  = '0;
            end
        endcase
        expected_q.push_back(damper_result());
    endtask

    always @(posedge i_clk) begin
        t_out_res e;
        if (!i_rst_n) begin
            m_stiff = '0; m_fric = '0; m_tol = 31'd1; m_dslope = 64'sd65536;
            m_mode = MODE_LINEAR; m_limit = 8'd2;
            m_strain = '0; m_rate = '0; m_crate = '0; m_count = '0;
            expected_q.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_STIFFNESS:      m_stiff  = 64'($signed(i_cfg_data));
                    REG_FRICTION_FORCE: m_fric   = i_cfg_data[30:0];
                    REG_RATE_TOLERANCE: m_tol    = i_cfg_data[30:0];
                    REG_DAMP_OUT_SLOPE: m_dslope = 64'($signed(i_cfg_data));
                    REG_DAMP_MODE:      m_mode   = i_cfg_data[1:0];
                    REG_FLIP_LIMIT:     m_limit  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) apply_request(i_req);
            if (i_res_valid && !i_res_stall) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", i_res);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e !== i_res) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     e.stress, e.damp_tangent, e.flip_count,
                                     i_res.stress, i_res.damp_tangent, i_res.flip_count);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

/* verif/coulomb_damper_friction_force_tb.sv */
// Testbench top for the friction damper: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module coulomb_damper_friction_force_tb;
    import cdff_pkg::*;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  req_valid = 0;
    logic                  req_stall;
    t_in_req               req = '0;
    logic                  res_valid;
    logic                  res_stall = 1;
    t_out_res              res;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors, pending, results;
    int                    sent = 0;
    bit                    hold_off = 0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    coulomb_damper_friction_force u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .o_stall(req_stall),
        .i_req(req), .o_valid(res_valid), .i_stall(res_stall), .o_res(res),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    coulomb_damper_friction_force_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(req_valid), .i_stall_in(req_stall),
        .i_req(req), .i_res_valid(res_valid), .i_res_stall(res_stall), .i_res(res),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(5, 60);
    endfunction

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 255) << 16;
            5: return -($urandom_range(0, 255) << 16);
            6: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n || hold_off) res_stall <= 1;
        else if ($urandom_range(0, 9) < 3) res_stall <= 1;
        else res_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0);
    end

    // valid stays high after acceptance; a later request with a gap, or drain(), drops it
    task automatic send_request(t_kind kind, logic [31:0] strain, logic [31:0] rate);
        int gap;
        gap = gap_len();
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1;
        req.kind     <= kind;
        req.strain   <= strain;
        req.strain_rate <= rate;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        cfg_we   <= 1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic drain();
        req_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_regs(logic [31:0] stiff, logic [31:0] fric, logic [31:0] tol,
                            logic [31:0] dslope, logic [1:0] mode, logic [7:0] lim);
        drain();
        write_reg(REG_STIFFNESS, stiff);
        write_reg(REG_FRICTION_FORCE, fric);
        write_reg(REG_RATE_TOLERANCE, tol);
        write_reg(REG_DAMP_OUT_SLOPE, dslope);
        write_reg(REG_DAMP_MODE, 32'(mode));
        write_reg(REG_FLIP_LIMIT, 32'(lim));
        cfg_we <= 0;
    endtask

    // oscillation: mostly trials alternating in sign, with commits, random trials and reverts mixed in
    task automatic swing_burst(int n);
        logic [31:0] mag;
        int r;
        for (int i = 0; i < n; i++) begin
            mag = $urandom_range(0, 8) << $urandom_range(8, 20);
            r = $urandom_range(0, 19);
            if (r < 12)
                send_request(KIND_TRIAL, edge_word(), (i % 2) ? -mag : mag);
            else if (r < 16) send_request(KIND_COMMIT, $urandom, $urandom);
            else if (r < 18) send_request(KIND_TRIAL, $urandom, $urandom);
            else if (r < 19) send_request(KIND_REVERT_COMMIT, $urandom, $urandom);
            else send_request(KIND_REVERT_START, $urandom, $urandom);
        end
    endtask

    initial begin
        #200000000;
        $display("coulomb_damper_friction_force verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset settings, then edge values
        send_request(KIND_TRIAL, 32'h0001_0000, 32'h0000_0001);
        send_request(KIND_COMMIT, 0, 0);
        send_request(KIND_TRIAL, 32'h7fff_ffff, 32'h8000_0000);
        send_request(KIND_TRIAL, 32'h8000_0000, 32'h7fff_ffff);
        set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h8000_0000, MODE_NONE, 0);
        send_request(KIND_TRIAL, 32'h7fff_ffff, 32'h0000_0001);
        send_request(KIND_COMMIT, 0, 0);
        send_request(KIND_TRIAL, 32'h8000_0000, 32'hffff_ffff);
        send_request(KIND_TRIAL, 32'h7fff_ffff, 32'h8000_0000);
        send_request(KIND_REVERT_COMMIT, 0, 0);
        set_regs(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 32'h0000_8000,
                 MODE_LINEAR, 0);
        send_request(KIND_TRIAL, 32'h0001_0000, 32'h0001_0000);   // band edge
        send_request(KIND_TRIAL, 32'h0001_0000, 32'hffff_0000);
        send_request(KIND_TRIAL, 32'h0001_0000, 32'h0000_8000);
        send_request(KIND_COMMIT, 0, 0);
        send_request(KIND_TRIAL, 32'h0001_0000, 32'hfffe_0000);   // flip
        send_request(KIND_TRIAL, 32'h0001_0000, 32'hfffe_0000);
        send_request(KIND_REVERT_START, 32'hffff_ffff, 32'hffff_ffff);
        set_regs(32'hffff_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 MODE_SCALED, 8'hff);
        send_request(KIND_TRIAL, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(KIND_COMMIT, 0, 0);
        send_request(KIND_TRIAL, 32'h8000_0000, 32'h8000_0000);

        // random phases through several settings
        for (int ph = 0; ph < 12; ph++) begin
            set_regs(edge_word(), $urandom_range(0, 7) == 0 ? 32'h7fff_ffff
                                                             : $urandom_range(0, 32'h000f_ffff),
                     $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000),
                     edge_word(), 2'($urandom_range(0, 3)),
                     8'($urandom_range(0, 5) == 0 ? 32'hff : $urandom_range(0, 4)));
            if (ph == 5) begin
                // long receiver hold-off while requests keep coming
                fork
                    begin
                        hold_off <= 1;
                        repeat (400) @(posedge clk);
                        hold_off <= 0;
                    end
                    begin
                        swing_burst(10);
                        req_valid <= 0;
                    end
                join
                @(posedge clk);
            end
            swing_burst(24);
        end
        // run a long unbroken series of reversed trials to saturate the flip counter
        set_regs(32'h0001_0000, 32'h0001_0000, 32'h100, 32'h0002_0000, MODE_LINEAR, 250);
        send_request(KIND_TRIAL, 0, 32'h0001_0000);
        send_request(KIND_COMMIT, 0, 0);
        for (int i = 0; i < 262; i++)
            send_request(KIND_TRIAL, $urandom, 32'hffff_0000);

        drain();
        $display("sent %0d requests under reset defaults and 16 register settings,",
                 sent);
        $display("with one long receiver hold-off; %0d results checked", results);
        if (errors == 0) begin
            $display("coulomb_damper_friction_force verification clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("coulomb_damper_friction_force verification failed");
        end
        $finish;
    end

endmodule

/* coulomb_damper_friction_force.f */
+incdir+design
design/cdff_pkg.sv
design/cdff_front.sv
design/cdff_queue.sv
design/cdff_back.sv
design/coulomb_damper_friction_force.sv
verif/coulomb_damper_friction_force_checker.sv
verif/coulomb_damper_friction_force_tb.sv
